// ===== sv/vsp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsp_pkg: shared types and constants
// Widths, register indexes, interpolation tables and controller types.
// ---------------------------------------------------------------------------
package vsp_pkg;

  localparam int STORED_POINTS = 35;
  localparam int TABLE_POINTS_DEF = 35;
  localparam int IDX_W = 6;

  localparam logic [1:0] REG_SEA_REF   = 2'd0;
  localparam logic [1:0] REG_RESP      = 2'd1;
  localparam logic [1:0] REG_MAX_DRIFT = 2'd2;

  localparam logic [16:0] SEA_REF_RST   = 17'd122552;
  localparam logic [15:0] RESP_RST      = 16'd1280;
  localparam logic [15:0] MAX_DRIFT_RST = 16'd3355;

  localparam logic [27:0] K_Q16 = 28'd193511811;
  localparam logic signed [19:0] SPEED_MAX = 20'sd524287;
  localparam logic signed [19:0] SPEED_MIN = -20'sd524288;

  function automatic logic [16:0] alt_x(input logic [IDX_W-1:0] i);
    logic [16:0] v;
    case (i)
      6'd0: v = 17'd0;       6'd1: v = 17'd12493;   6'd2: v = 17'd24003;
      6'd3: v = 17'd34447;   6'd4: v = 17'd43991;   6'd5: v = 17'd52716;
      6'd6: v = 17'd60539;   6'd7: v = 17'd67789;   6'd8: v = 17'd74260;
      6'd9: v = 17'd80364;   6'd10: v = 17'd85279;  6'd11: v = 17'd89948;
      6'd12: v = 17'd94249;  6'd13: v = 17'd97935;  6'd14: v = 17'd101212;
      6'd15: v = 17'd104038; 6'd16: v = 17'd106496; 6'd17: v = 17'd108585;
      6'd18: v = 17'd110428; 6'd19: v = 17'd112026; 6'd20: v = 17'd113377;
      6'd21: v = 17'd114606; 6'd22: v = 17'd115671; 6'd23: v = 17'd116531;
      6'd24: v = 17'd117268; 6'd25: v = 17'd118006; 6'd26: v = 17'd118620;
      6'd27: v = 17'd119112; 6'd28: v = 17'd119603; 6'd29: v = 17'd119972;
      6'd30: v = 17'd120340; 6'd31: v = 17'd120586; 6'd32: v = 17'd120832;
      6'd33: v = 17'd121078; default: v = 17'd121324;
    endcase
    return v;
  endfunction

  function automatic logic [20:0] alt_y(input logic [IDX_W-1:0] i);
    logic [20:0] v;
    case (i)
      6'd0: v = 21'd0;       6'd1: v = 21'd47244;   6'd2: v = 21'd94488;
      6'd3: v = 21'd141732;  6'd4: v = 21'd188976;  6'd5: v = 21'd236220;
      6'd6: v = 21'd283465;  6'd7: v = 21'd330709;  6'd8: v = 21'd377953;
      6'd9: v = 21'd425197;  6'd10: v = 21'd472441; 6'd11: v = 21'd519685;
      6'd12: v = 21'd566929; 6'd13: v = 21'd614173; 6'd14: v = 21'd661417;
      6'd15: v = 21'd708661; 6'd16: v = 21'd755906; 6'd17: v = 21'd803150;
      6'd18: v = 21'd850394; 6'd19: v = 21'd897638; 6'd20: v = 21'd944882;
      6'd21: v = 21'd992126; 6'd22: v = 21'd1039370; 6'd23: v = 21'd1086614;
      6'd24: v = 21'd1133858; 6'd25: v = 21'd1181102; 6'd26: v = 21'd1228346;
      6'd27: v = 21'd1275591; 6'd28: v = 21'd1322835; 6'd29: v = 21'd1370079;
      6'd30: v = 21'd1417323; 6'd31: v = 21'd1464567; 6'd32: v = 21'd1511811;
      6'd33: v = 21'd1559055; default: v = 21'd1606299;
    endcase
    return v;
  endfunction

  function automatic logic [17:0] slope_y(input logic [IDX_W-1:0] i);
    logic [17:0] v;
    case (i)
      6'd0: v = 18'd218235;  6'd1: v = 18'd199885;  6'd2: v = 18'd184156;
      6'd3: v = 18'd167117;  6'd4: v = 18'd152699;  6'd5: v = 18'd139592;
      6'd6: v = 18'd125174;  6'd7: v = 18'd115999;  6'd8: v = 18'd103547;
      6'd9: v = 18'd97649;   6'd10: v = 18'd78643;  6'd11: v = 18'd74711;
      6'd12: v = 18'd68813;  6'd13: v = 18'd58982;  6'd14: v = 18'd52429;
      6'd15: v = 18'd45220;  6'd16: v = 18'd39322;  6'd17: v = 18'd33423;
      6'd18: v = 18'd29491;  6'd19: v = 18'd25559;  6'd20: v = 18'd21627;
      6'd21: v = 18'd19661;  6'd22: v = 18'd17039;  6'd23: v = 18'd13763;
      6'd24: v = 18'd11796;  6'd25: v = 18'd11796;  6'd26: v = 18'd9830;
      6'd27: v = 18'd7864;   6'd28: v = 18'd7864;   6'd29: v = 18'd5898;
      6'd30: v = 18'd5898;   6'd31: v = 18'd3932;   6'd32: v = 18'd3932;
      6'd33: v = 18'd3932;   default: v = 18'd3932;
    endcase
    return v;
  endfunction

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_DT     = 15'b000000000000010,
    ST_DRIFT  = 15'b000000000000100,
    ST_ASRCH  = 15'b000000000001000,
    ST_AMUL   = 15'b000000000010000,
    ST_ADIV   = 15'b000000000100000,
    ST_SSRCH  = 15'b000000001000000,
    ST_SMUL   = 15'b000000010000000,
    ST_SDIV   = 15'b000000100000000,
    ST_VDIV   = 15'b000001000000000,
    ST_FDIF   = 15'b000010000000000,
    ST_FINC   = 15'b000100000000000,
    ST_FILT   = 15'b001000000000000,
    ST_FPM    = 15'b010000000000000,
    ST_OUT    = 15'b100000000000000
  } vsp_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic do_dt;
    logic do_drift;
    logic srch_init; // start segment search
    logic srch_step;
    logic srch_sel;  // 0 altitude, 1 slope
    logic do_mul;    // interpolation product
    logic div_start;
    logic div_sel;   // 0 interpolation, 1 speed
    logic div_step;
    logic do_filt_mul;
    logic do_filt;
    logic do_fpm;
    logic commit;
  } vsp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic srch_done;
    logic div_done;
    logic drift_ok;
  } vsp_sts_t;

endpackage

// ===== sv/vsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsp channel interfaces
// Valid/ready channels for input ticks, results and register writes.
// ---------------------------------------------------------------------------
interface vsp_in_if;
  logic        valid;
  logic        ready;
  logic        serviceable;
  logic        frozen;
  logic [16:0] static_pressure;
  logic [16:0] sea_pressure;
  logic [17:0] elapsed_time;
  logic [15:0] sim_rate;
  modport source (output valid, serviceable, frozen, static_pressure, sea_pressure,
                  elapsed_time, sim_rate, input ready);
  modport sink (input valid, serviceable, frozen, static_pressure, sea_pressure,
                elapsed_time, sim_rate, output ready);
endinterface

interface vsp_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] speed_fps;
  logic [21:0] speed_fpm;
  logic        speed_recomputed;
  modport source (output valid, speed_fps, speed_fpm, speed_recomputed, input ready);
  modport sink (input valid, speed_fps, speed_fpm, speed_recomputed, output ready);
endinterface

interface vsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/vsp_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsp_ctrl: sequencing state machine
// Steps one tick through dt, drift check, lookups, divides, filter and fpm.
// ---------------------------------------------------------------------------
module vsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ignore,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vsp_pkg::vsp_cmd_t cmd,
  input  vsp_pkg::vsp_sts_t sts
);
  import vsp_pkg::*;

  vsp_state_t state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  // new tick only once the previous result left
  assign in_ready  = (state_r == ST_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready && !in_ignore) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DT;
        end
      end
      ST_DT: begin
        cmd.do_dt = 1'b1;
        state_nxt = ST_DRIFT;
      end
      ST_DRIFT: begin
        cmd.do_drift = 1'b1;
        state_nxt    = ST_ASRCH;
      end
      ST_ASRCH: begin
        if (!sts.drift_ok) begin
          state_nxt = ST_FPM;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = ST_AMUL;
        end
      end
      ST_AMUL: begin
        if (sts.srch_done) begin
          cmd.do_mul = 1'b1;
          state_nxt  = ST_ADIV;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_ADIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_SSRCH;
        end
      end
      ST_SSRCH: begin
        cmd.srch_init = 1'b1;
        cmd.srch_sel  = 1'b1;
        state_nxt     = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.srch_sel = 1'b1;
        if (sts.srch_done) begin
          cmd.do_mul = 1'b1;
          state_nxt  = ST_SDIV;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_SDIV: begin
        cmd.srch_sel = 1'b1;
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = ST_VDIV;
        end
      end
      ST_VDIV: begin
        cmd.div_sel  = 1'b1;
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.do_filt_mul = 1'b1;
          state_nxt       = ST_FDIF;
        end
      end
      // filter difference, then increment product, settle in the datapath
      ST_FDIF: begin
        state_nxt = ST_FINC;
      end
      ST_FINC: begin
        state_nxt = ST_FILT;
      end
      ST_FILT: begin
        cmd.do_filt = 1'b1;
        state_nxt   = ST_FPM;
      end
      ST_FPM: begin
        cmd.do_fpm = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        cmd.commit = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !ovalid_r) else $error("load with pending result");
  a_out_follows_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ovalid_r) else $error("commit lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> ovalid_r) else $error("result dropped");
  a_idle_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (state_r == ST_IDLE)) else $error("busy with result out");

endmodule

// ===== sv/vsp_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsp_dp: arithmetic datapath
// Registers, segment search, shared restoring divider, filter and output.
// ---------------------------------------------------------------------------
module vsp_dp #(
  parameter int TABLE_POINTS = vsp_pkg::TABLE_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [16:0]       cfg_data,
  input  logic [16:0]       in_static_pressure,
  input  logic [16:0]       in_sea_pressure,
  input  logic [17:0]       in_elapsed_time,
  input  logic [15:0]       in_sim_rate,
  input  vsp_pkg::vsp_cmd_t cmd,
  output vsp_pkg::vsp_sts_t sts,
  output logic [19:0]       speed_fps,
  output logic [21:0]       speed_fpm,
  output logic              speed_recomputed
);
  import vsp_pkg::*;

  localparam int NPTS = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                        ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NPTS - 1);
  localparam logic [IDX_W-1:0] SRCH_END = IDX_W'(NPTS - 2);
  // widest divide: 17+12+28 bit numerator
  localparam int DW = 57;

  logic [16:0] sea_ref_r, last_p_r, last_sea_r, p_r, sea_r;
  logic [15:0] resp_r, maxd_r, su_r;
  logic [17:0] et_r;
  logic signed [19:0] filt_r, raw_r;
  logic [25:0] dt_r;
  logic        drift_ok_r, recomp_r;
  logic [IDX_W-1:0] idx_r;
  logic [20:0] xq_r;      // search key (altitude or pressure difference)
  logic [20:0] alt_r;
  logic [DW-1:0] num_r, quo_r, rem_r;
  logic [43:0]  den_r;
  logic [5:0]   cnt_r;
  logic         dneg_r;
  logic [20:0]  base_r;
  logic signed [21:0] fpm_r;
  logic signed [20:0] diff_r;
  logic [41:0]  alpha_r;
  logic [62:0]  inc_r;

  // table access for current search
  logic [20:0] tx0, tx1, ty0, ty1;
  always_comb begin
    if (!cmd.srch_sel) begin
      tx0 = {4'd0, alt_x(idx_r)};
      tx1 = {4'd0, alt_x(idx_r + 1'b1)};
      ty0 = alt_y(idx_r);
      ty1 = alt_y(idx_r + 1'b1);
    end else begin
      tx0 = alt_y(idx_r);
      tx1 = alt_y(idx_r + 1'b1);
      ty0 = {3'd0, slope_y(idx_r)};
      ty1 = {3'd0, slope_y(idx_r + 1'b1)};
    end
  end

  logic srch_hit;
  assign srch_hit = (xq_r < tx1) || (idx_r == SRCH_END);
  assign sts.srch_done = srch_hit;
  assign sts.div_done  = (cnt_r == 6'd0);
  assign sts.drift_ok  = drift_ok_r;

  // signed key: sea_ref - p, may be negative (clamps low)
  logic signed [17:0] adiff;
  assign adiff = $signed({1'b0, sea_ref_r}) - $signed({1'b0, p_r});

  logic [20:0] key_first, key_last, yv0, yvl;
  always_comb begin
    key_first = cmd.srch_sel ? alt_y(6'd0) : {4'd0, alt_x(6'd0)};
    key_last  = cmd.srch_sel ? alt_y(LAST) : {4'd0, alt_x(LAST)};
    yv0 = cmd.srch_sel ? {3'd0, slope_y(6'd0)} : alt_y(6'd0);
    yvl = cmd.srch_sel ? {3'd0, slope_y(LAST)} : alt_y(LAST);
  end
  logic [20:0] key_now;
  logic        key_neg;
  assign key_now = cmd.srch_sel ? alt_r : {4'd0, adiff[16:0]};
  assign key_neg = !cmd.srch_sel && adiff[17];

  // restoring divider step
  logic [DW:0]  trial;
  logic [DW-1:0] rem_sh;
  assign rem_sh = {rem_r[DW-2:0], num_r[DW-1]};
  assign trial  = {1'b0, rem_sh} - {{(DW-43){1'b0}}, den_r};

  logic [33:0] dmag, dlim;
  logic signed [17:0] dsea, dp;
  assign dsea = $signed({1'b0, sea_r}) - $signed({1'b0, last_sea_r});
  assign dp   = $signed({1'b0, p_r}) - $signed({1'b0, last_p_r});
  assign dmag = dsea[17] ? 34'(-dsea) : 34'(dsea);
  assign dlim = 34'((42'(maxd_r) * 42'(dt_r)) >> 28);

  logic [16:0] dpmag;
  assign dpmag = dp[17] ? 17'(-dp) : 17'(dp);

  logic signed [20:0] fnext;
  logic signed [20:0] incs;
  assign incs  = diff_r[20] ? -$signed({1'b0, inc_r[43:24]}) : $signed({1'b0, inc_r[43:24]});
  assign fnext = $signed({filt_r[19], filt_r}) + incs;

  logic signed [23:0] f15;
  assign f15 = $signed({{4{filt_r[19]}}, filt_r}) * 24'sd15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sea_ref_r  <= SEA_REF_RST;
      resp_r     <= RESP_RST;
      maxd_r     <= MAX_DRIFT_RST;
      last_p_r   <= SEA_REF_RST;
      last_sea_r <= SEA_REF_RST;
      filt_r     <= '0;
      fpm_r      <= '0;
      recomp_r   <= 1'b0;
      drift_ok_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SEA_REF:   sea_ref_r <= cfg_data;
          REG_RESP:      resp_r    <= cfg_data[15:0];
          REG_MAX_DRIFT: maxd_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        p_r <= in_static_pressure;
        sea_r <= in_sea_pressure;
        et_r <= in_elapsed_time;
        su_r <= in_sim_rate;
        recomp_r <= 1'b0;
      end
      if (cmd.do_dt) begin
        dt_r <= (su_r > 16'd256) ? 26'((34'(et_r) * 34'(su_r)) >> 8) : 26'(et_r);
      end
      if (cmd.do_drift) begin
        // |d|<<28 < m*dt  <=>  |d| < ceil(m*dt / 2^28)
        drift_ok_r <= (dmag < (dlim + 34'(|(42'(maxd_r) * 42'(dt_r) & 42'hFFFFFFF))));
      end
      if (cmd.srch_init) begin
        idx_r <= '0;
        // keys at or below the first entry clamp low
        xq_r  <= (key_neg || key_now <= key_first) ? key_first : key_now;
      end
      if (cmd.srch_step && !srch_hit) idx_r <= idx_r + 1'b1;
      if (cmd.do_mul) begin
        // clamp handling: key at/beyond last -> last entry, at/below first -> first
        if (xq_r >= key_last) begin
          base_r <= yvl; num_r <= '0; dneg_r <= 1'b0;
        end else if (xq_r <= key_first) begin
          base_r <= yv0; num_r <= '0; dneg_r <= 1'b0;
        end else begin
          base_r <= ty0;
          dneg_r <= ty1 < ty0;
          num_r  <= DW'(42'(xq_r - tx0) * 42'((ty1 < ty0) ? ty0 - ty1 : ty1 - ty0));
        end
        den_r <= 44'(tx1 - tx0);
        rem_r <= '0; quo_r <= '0; cnt_r <= 6'(DW);
      end
      if (cmd.div_step && cnt_r != 6'd0) begin
        num_r <= num_r << 1;
        if (!trial[DW]) begin
          rem_r <= trial[DW-1:0];
          quo_r <= {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.div_step && cnt_r == 6'd0 && !cmd.div_sel && !cmd.srch_sel) begin
        alt_r <= dneg_r ? base_r - 21'(quo_r) : base_r + 21'(quo_r);
      end
      // slope result feeds the speed divisor directly
      if (cmd.div_start) begin
        num_r  <= DW'(57'({dpmag, 12'd0}) * 57'(K_Q16));
        den_r  <= 44'(dt_r) * 44'(dneg_r ? base_r - 21'(quo_r) : base_r + 21'(quo_r));
        dneg_r <= !dp[17] && dp != 18'sd0;
        rem_r  <= '0; quo_r <= '0; cnt_r <= 6'(DW);
        alpha_r <= 42'(dt_r) * 42'(resp_r);
      end
      if (cmd.do_filt_mul) begin
        raw_r  <= dneg_r ? ((quo_r > 57'd524288) ? SPEED_MIN : 20'(-$signed(21'(quo_r))))
                         : ((quo_r > 57'd524287) ? SPEED_MAX : 20'(quo_r));
      end
      if (cmd.do_filt) begin
        // diff and increment settled during the two wait states
        filt_r   <= (alpha_r >= 42'h1000000) ? raw_r : fnext[19:0];
        recomp_r <= 1'b1;
      end
      if (cmd.do_fpm) begin
        fpm_r <= 22'(f15[23] ? -((-f15) >>> 2) : (f15 >>> 2));
      end
      if (cmd.commit) begin
        last_p_r   <= p_r;
        last_sea_r <= sea_r;
      end
    end
  end

  // filter difference and increment, registered after raw
  always_ff @(posedge clk) begin
    diff_r <= $signed({raw_r[19], raw_r}) - $signed({filt_r[19], filt_r});
    inc_r  <= 63'(21'(diff_r[20] ? -diff_r : diff_r)) * 63'(alpha_r[23:0]);
  end

  assign speed_fps        = filt_r;
  assign speed_fpm        = fpm_r;
  assign speed_recomputed = recomp_r;

  a_div_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && cnt_r != 6'd0) |=> (cnt_r == $past(cnt_r) - 6'd1))
    else $error("divider count");
  a_commit_stores: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (last_p_r == $past(p_r))) else $error("pressure not stored");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= SRCH_END || !(cmd.srch_step)) else $error("search overrun");

endmodule

// ===== sv/vertical_speed_from_pressure_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertical_speed_from_pressure_core: vertical speed from static pressure
// Tick in, filtered vertical speed out, with three writable registers.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_*    | in  | serviceable, frozen, pressures, elapsed time, sim rate
//  out_*   | out | speed_fps, speed_fpm, speed_recomputed
//  cfg_*   | in  | register index, write data
//
// An accepted tick runs dt, drift check, a segment search in each table (up
// to 33 steps per table) and three 57-bit restoring divides (one quotient bit
// a cycle), then filter and fpm.
// A tick that fails the drift check goes from the drift check straight to fpm.
// Ignored ticks finish in the accept cycle and give no beat.
// rst_n is synchronous; it restores registers and the stored pressures.
// A new tick is taken only after the previous result beat has left.
// ---------------------------------------------------------------------------
module vertical_speed_from_pressure_core #(
  parameter int TABLE_POINTS = vsp_pkg::TABLE_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vsp_in_if.sink      in_ch,
  vsp_out_if.source   out_ch,
  vsp_cfg_if.sink     cfg_ch
);
  import vsp_pkg::*;

  vsp_cmd_t cmd;
  vsp_sts_t sts;
  logic     ignore;

  // ticks that are ignored leave state untouched
  assign ignore = !in_ch.serviceable || in_ch.frozen || (in_ch.elapsed_time == 18'd0);
  assign cfg_ch.ready = 1'b1;

  vsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ignore (ignore),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vsp_dp #(.TABLE_POINTS(TABLE_POINTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_ch.valid),
    .cfg_idx            (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .in_static_pressure (in_ch.static_pressure),
    .in_sea_pressure    (in_ch.sea_pressure),
    .in_elapsed_time    (in_ch.elapsed_time),
    .in_sim_rate        (in_ch.sim_rate),
    .cmd                (cmd),
    .sts                (sts),
    .speed_fps          (out_ch.speed_fps),
    .speed_fpm          (out_ch.speed_fpm),
    .speed_recomputed   (out_ch.speed_recomputed)
  );

endmodule
